// File: rtl/core/rcam_pkg.sv
// Shared constants, codes and types for the RC channel axis mapper.
// No dependencies; imported by rcam_cfg, the top level, the checker and the testbench.
package rcam_pkg;

  localparam int RCAM_CHANNELS = 8;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int CH_W     = 3;
  localparam int AXIS_W   = 16;
  localparam int PULSE_W  = 8;
  localparam int OFFSET_W = 8;
  localparam int GAIN_W   = 7;
  localparam int MASK_W   = 8;
  localparam int DZ_W     = 7;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_MAP  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRIM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GAIN = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REV  = 2'd3;

  // Reset values and limits
  localparam logic [PULSE_W-1:0]  PULSE_RESET   = 8'd155;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 8'd155;
  localparam logic [OFFSET_W-1:0] OFFSET0_RESET = 8'd162;
  localparam logic [GAIN_W-1:0]   GAIN_RESET    = 7'd30;
  localparam logic [DZ_W-1:0]     DZ_RESET      = 7'd20;
  localparam logic [MASK_W-1:0]   REVERSE_RESET = 8'd8;
  localparam int PULSE_MIN    = 60;
  localparam int PULSE_MAX    = 250;
  localparam int OFFSET_MIN   = 100;
  localparam int OFFSET_MAX   = 220;
  localparam int GAIN_DEC_MIN = 20;
  localparam int GAIN_INC_MAX = 75;

  // Floor divide by 100: bias to non-negative, multiply by reciprocal, shift.
  // Exact for biased values below 2**PROD_W.
  localparam int PROD_W     = 23;
  localparam int RECIP_W    = 24;
  localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
  localparam int DIV_SHIFT  = 30;
  localparam int Q_W        = 17;
  localparam int DIV_BIAS   = 2500000;
  localparam int DIV_BIAS_Q = 25000;

  // Register file
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_DEADZONE = 1'b0;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [GAIN_W-1:0]   gain;
  } og_t;

  localparam og_t OG_RESET0 = '{offset: OFFSET0_RESET, gain: GAIN_RESET};
  localparam og_t OG_RESETN = '{offset: OFFSET_RESET,  gain: GAIN_RESET};

endpackage

// File: rtl/core/rcam_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rcam_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rcam_store.sv
// Per-channel store: RAM plus per-entry valid bits giving reset values,
// and write-first forwarding for a read and write to one entry in one cycle.
// Depends on rcam_ram.
module rcam_store #(
  parameter int              WIDTH     = 8,
  parameter int              DEPTH     = 8,
  parameter logic [WIDTH-1:0] RST_FIRST = '0,
  parameter logic [WIDTH-1:0] RST_REST  = '0,
  localparam int             AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [DEPTH-1:0] valid_r;
  logic             fwd_r;
  logic             vld_r;
  logic             first_r;
  logic [WIDTH-1:0] fwd_data_r;
  logic [WIDTH-1:0] ram_q;

  rcam_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fwd_r   <= 1'b0;
      vld_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_r   <= wr_en && (wr_addr == rd_addr);
        vld_r   <= valid_r[rd_addr];
        first_r <= (rd_addr == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  // never-written entries read as their reset value
  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (vld_r) begin
      rd_data = ram_q;
    end else if (first_r) begin
      rd_data = RST_FIRST;
    end else begin
      rd_data = RST_REST;
    end
  end

endmodule

// File: rtl/core/rcam_cfg.sv
// APB register file: holds the shared deadzone register.
// Depends on rcam_pkg.
module rcam_cfg
  import rcam_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [DZ_W-1:0]   deadzone
);

  logic [DZ_W-1:0] dz_r;
  logic            reg_sel;
  logic            wr_stb;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1];
  assign wr_stb  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (wr_stb && (reg_sel == REG_DEADZONE)) begin
      dz_r <= pwdata[DZ_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_DEADZONE) begin
      prdata = APB_DW'(dz_r);
    end
  end

  assign deadzone = dz_r;

endmodule

// File: rtl/core/rc_channel_axis_mapper_top.sv
// RC channel axis mapper, top level: four-stage pipeline around two stores.
// Depends on rcam_pkg, rcam_store, rcam_cfg.
//
// Takes one word per cycle and returns one result word per input word, in
// order, from the output register. Stage 1 does read-modify-write of the
// offset/gain store (read issued at acceptance), stage 2 divides the scaled
// axis by 100 through a reciprocal multiply, stage 3 clamps and does
// read-modify-write of the pulse store (read issued from stage 2); both
// stores forward a write to a read of the same channel in the same cycle, so
// back-to-back words on one channel need no interlock. in_stall rises only
// while the output register holds a word under out_stall. Stores come up
// with their reset values at once; there is no clearing pass. The deadzone
// register sits at byte address 0 and may only be written while idle.
module rc_channel_axis_mapper_top
  import rcam_pkg::*;
#(
  parameter int CHANNELS = RCAM_CHANNELS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic                     in_event_is_axis,
  input  logic [CH_W-1:0]          in_channel,
  input  logic signed [AXIS_W-1:0] in_axis_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          out_channel,
  output logic [PULSE_W-1:0]       out_pulse_value,
  output logic [OFFSET_W-1:0]      out_trim_offset,
  output logic [GAIN_W-1:0]        out_gain_hundredths,
  output logic [MASK_W-1:0]        out_reverse_mask,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int CMP_W  = ((CH_W > CNT_W) ? CH_W : CNT_W) + 1;
  localparam int A_W    = AXIS_W + 1;
  localparam int MUL_W  = A_W + GAIN_W + 1;
  localparam int DIVM_W = PROD_W + RECIP_W;
  localparam int SUM_W  = Q_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(PULSE_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(PULSE_MIN);
  localparam logic signed [SUM_W-1:0] SUM_BIAS = SUM_W'(DIV_BIAS_Q);

  logic            adv;
  logic [DZ_W-1:0] deadzone;
  logic [MASK_W-1:0] rev_r;
  logic [MASK_W-1:0] rev_nxt;

  // stage 1
  logic                     s1_valid_r;
  logic [FUNC_W-1:0]        s1_func_r;
  logic                     s1_axis_evt_r;
  logic [CH_W-1:0]          s1_ch_r;
  logic signed [AXIS_W-1:0] s1_axis_r;
  // stage 2
  logic                     s2_valid_r;
  logic [CH_W-1:0]          s2_ch_r;
  logic                     s2_inr_r;
  logic                     s2_map_r;
  og_t                      s2_og_r;
  logic [MASK_W-1:0]        s2_mask_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  // stage 3
  logic                     s3_valid_r;
  logic [CH_W-1:0]          s3_ch_r;
  logic                     s3_inr_r;
  logic                     s3_map_r;
  og_t                      s3_og_r;
  logic [MASK_W-1:0]        s3_mask_r;
  logic [Q_W-1:0]           s3_q_r;
  // output register
  logic                     out_valid_r;
  logic [CH_W-1:0]          out_ch_r;
  logic [PULSE_W-1:0]       out_pulse_r;
  logic [OFFSET_W-1:0]      out_offset_r;
  logic [GAIN_W-1:0]        out_gain_r;
  logic [MASK_W-1:0]        out_mask_r;

  // stage 1 logic
  og_t                   og_rd;
  og_t                   og_upd;
  logic                  s1_inr;
  logic                  negate;
  logic                  low;
  logic                  high;
  logic signed [A_W-1:0] a_ext;
  logic signed [A_W-1:0] a_adj;
  logic signed [A_W-1:0] dz_ext;
  logic signed [A_W-1:0] t_val;
  logic signed [MUL_W-1:0] mul1;
  // stage 2 logic
  logic [PROD_W-1:0]     div_x;
  logic [DIVM_W-1:0]     div_m;
  // stage 3 logic
  logic [PULSE_W-1:0]     pulse_rd;
  logic [PULSE_W-1:0]     pulse_fin;
  logic signed [SUM_W-1:0] sum;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  rcam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .deadzone(deadzone)
  );

  rcam_store #(
    .WIDTH    ($bits(og_t)),
    .DEPTH    (CHANNELS),
    .RST_FIRST(OG_RESET0),
    .RST_REST (OG_RESETN)
  ) u_og_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (adv),
    .rd_addr(AW'(in_channel)),
    .rd_data(og_rd),
    .wr_en  (adv && s1_valid_r && s1_inr),
    .wr_addr(AW'(s1_ch_r)),
    .wr_data(og_upd)
  );

  rcam_store #(
    .WIDTH    (PULSE_W),
    .DEPTH    (CHANNELS),
    .RST_FIRST(PULSE_RESET),
    .RST_REST (PULSE_RESET)
  ) u_pulse_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (adv),
    .rd_addr(AW'(s2_ch_r)),
    .rd_data(pulse_rd),
    .wr_en  (adv && s3_valid_r && s3_inr_r),
    .wr_addr(AW'(s3_ch_r)),
    .wr_data(pulse_fin)
  );

  // ---------------- stage 1: deadzone, offset/gain/reverse update, scale
  always_comb begin
    s1_inr = CMP_W'(s1_ch_r) < CMP_W'(CHANNELS);
    negate = (s1_func_r == FUNC_MAP) && s1_axis_evt_r && rev_r[s1_ch_r];
    a_ext  = {s1_axis_r[AXIS_W-1], s1_axis_r};
    a_adj  = negate ? -a_ext : a_ext;
    dz_ext = $signed({{(A_W-DZ_W){1'b0}}, deadzone});
    low    = a_adj < -dz_ext;
    high   = a_adj > dz_ext;
    if (low) begin
      t_val = a_adj + dz_ext;
    end else if (high) begin
      t_val = a_adj - dz_ext;
    end else begin
      t_val = '0;
    end
    mul1 = t_val * $signed({1'b0, og_rd.gain});

    og_upd  = og_rd;
    rev_nxt = rev_r;
    unique case (s1_func_r)
      FUNC_MAP: begin
        og_upd = og_rd;
      end
      FUNC_TRIM: begin
        if (low && (og_rd.offset > OFFSET_W'(OFFSET_MIN))) begin
          og_upd.offset = og_rd.offset - 1'b1;
        end else if (high && (og_rd.offset < OFFSET_W'(OFFSET_MAX))) begin
          og_upd.offset = og_rd.offset + 1'b1;
        end
      end
      FUNC_GAIN: begin
        if (low && (og_rd.gain >= GAIN_W'(GAIN_DEC_MIN))) begin
          og_upd.gain = og_rd.gain - 1'b1;
        end else if (high && (og_rd.gain <= GAIN_W'(GAIN_INC_MAX))) begin
          og_upd.gain = og_rd.gain + 1'b1;
        end
      end
      FUNC_REV: begin
        if (s1_inr && low) begin
          rev_nxt[s1_ch_r] = 1'b1;
        end else if (s1_inr && high) begin
          rev_nxt[s1_ch_r] = 1'b0;
        end
      end
      default: begin
        og_upd = og_rd;
      end
    endcase
  end

  // ---------------- stage 2: floor(p / 100) by reciprocal multiply
  always_comb begin
    div_x = PROD_W'(s2_prod_r) + PROD_W'(DIV_BIAS);
    div_m = DIVM_W'(div_x) * DIVM_W'(RECIP);
  end

  // ---------------- stage 3: add offset, clamp
  always_comb begin
    sum = $signed({2'b00, s3_q_r}) - SUM_BIAS
          + $signed({{(SUM_W-OFFSET_W){1'b0}}, s3_og_r.offset});
    if (!s3_map_r) begin
      pulse_fin = pulse_rd;
    end else if (sum > SUM_MAX) begin
      pulse_fin = PULSE_W'(PULSE_MAX);
    end else if (sum < SUM_MIN) begin
      pulse_fin = PULSE_W'(PULSE_MIN);
    end else begin
      pulse_fin = sum[PULSE_W-1:0];
    end
  end

  // ---------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rev_r       <= REVERSE_RESET;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
      if (s1_valid_r) begin
        rev_r <= rev_nxt;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r     <= in_func;
      s1_axis_evt_r <= in_event_is_axis;
      s1_ch_r       <= in_channel;
      s1_axis_r     <= in_axis_value;

      s2_ch_r   <= s1_ch_r;
      s2_inr_r  <= s1_inr;
      s2_map_r  <= (s1_func_r == FUNC_MAP) && s1_axis_evt_r;
      s2_og_r   <= og_upd;
      s2_mask_r <= rev_nxt;
      s2_prod_r <= mul1[PROD_W-1:0];

      s3_ch_r   <= s2_ch_r;
      s3_inr_r  <= s2_inr_r;
      s3_map_r  <= s2_map_r;
      s3_og_r   <= s2_og_r;
      s3_mask_r <= s2_mask_r;
      s3_q_r    <= div_m[DIV_SHIFT +: Q_W];

      out_ch_r   <= s3_ch_r;
      out_mask_r <= s3_mask_r;
      if (s3_inr_r) begin
        out_pulse_r  <= pulse_fin;
        out_offset_r <= s3_og_r.offset;
        out_gain_r   <= s3_og_r.gain;
      end else begin
        out_pulse_r  <= '0;
        out_offset_r <= '0;
        out_gain_r   <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_channel         = out_ch_r;
  assign out_pulse_value     = out_pulse_r;
  assign out_trim_offset     = out_offset_r;
  assign out_gain_hundredths = out_gain_r;
  assign out_reverse_mask    = out_mask_r;

endmodule

// File: rtl/core/rcam_checker.sv
// Port-level assertions for the RC channel axis mapper, bound to the top.
// Depends on rcam_pkg and rc_channel_axis_mapper_top.
module rcam_checker
  import rcam_pkg::*;
#(
  parameter int CHANNELS = RCAM_CHANNELS
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CH_W-1:0]     out_channel,
  input logic [PULSE_W-1:0]  out_pulse_value,
  input logic [OFFSET_W-1:0] out_trim_offset,
  input logic [GAIN_W-1:0]   out_gain_hundredths
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int CMP_W = ((CH_W > CNT_W) ? CH_W : CNT_W) + 1;

  logic ch_ok;
  assign ch_ok = CMP_W'(out_channel) < CMP_W'(CHANNELS);

  // a held result word keeps its channel, pulse value and trim offset
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel)
      && $stable(out_pulse_value) && $stable(out_trim_offset))
    else $error("result word changed under stall");

  // input is held back only by a stalled result word
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ch_ok |->
      out_pulse_value >= PULSE_W'(PULSE_MIN) && out_pulse_value <= PULSE_W'(PULSE_MAX)
      && out_trim_offset >= OFFSET_W'(OFFSET_MIN)
      && out_trim_offset <= OFFSET_W'(OFFSET_MAX)
      && out_gain_hundredths >= GAIN_W'(GAIN_DEC_MIN - 1)
      && out_gain_hundredths <= GAIN_W'(GAIN_INC_MAX + 1))
    else $error("channel value out of range");

  a_bad_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ch_ok |->
      out_pulse_value == '0 && out_trim_offset == '0 && out_gain_hundredths == '0)
    else $error("unused channel reported non-zero values");

endmodule

bind rc_channel_axis_mapper_top rcam_checker #(.CHANNELS(CHANNELS)) u_rcam_checker (.*);

// File: sim/tb_rc_channel_axis_mapper_top.sv
// Self-checking testbench for rc_channel_axis_mapper_top: queue-fed driver, checking monitor,
// APB writes of the deadzone register and a per-word channel-state predictor.
// Depends on rcam_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_rc_channel_axis_mapper_top
  import rcam_pkg::*;
;

  localparam int LIMIT = 400000;
  localparam logic [APB_AW-1:0] DZ_ADDR    = APB_AW'(4 * int'(REG_DEADZONE));
  localparam logic [APB_AW-1:0] UNUSED_ADDR = APB_AW'(4);  // index 1, not mapped

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic                     is_axis;
    logic [CH_W-1:0]          channel;
    logic signed [AXIS_W-1:0] axis;
  } axis_word_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [PULSE_W-1:0]  pulse;
    logic [OFFSET_W-1:0] offset;
    logic [GAIN_W-1:0]   gain;
    logic [MASK_W-1:0]   mask;
  } chan_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_W-1:0]        in_func = '0;
  logic                     in_event_is_axis = 1'b0;
  logic [CH_W-1:0]          in_channel = '0;
  logic signed [AXIS_W-1:0] in_axis_value = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CH_W-1:0]          out_channel;
  logic [PULSE_W-1:0]       out_pulse_value;
  logic [OFFSET_W-1:0]      out_trim_offset;
  logic [GAIN_W-1:0]        out_gain_hundredths;
  logic [MASK_W-1:0]        out_reverse_mask;

  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  // predictor state
  logic [PULSE_W-1:0]  pulse_mem  [RCAM_CHANNELS];
  logic [OFFSET_W-1:0] offset_mem [RCAM_CHANNELS];
  logic [GAIN_W-1:0]   gain_mem   [RCAM_CHANNELS];
  logic [MASK_W-1:0]   rev_mask;
  logic [DZ_W-1:0]     dz_shadow;

  axis_word_t word_q[$];
  chan_word_t chan_q[$];
  axis_word_t next_word;
  chan_word_t want_word;
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int mism_cnt = 0;
  int cycle_cnt = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  rc_channel_axis_mapper_top #(.CHANNELS(RCAM_CHANNELS)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_event_is_axis    (in_event_is_axis),
    .in_channel          (in_channel),
    .in_axis_value       (in_axis_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel         (out_channel),
    .out_pulse_value     (out_pulse_value),
    .out_trim_offset     (out_trim_offset),
    .out_gain_hundredths (out_gain_hundredths),
    .out_reverse_mask    (out_reverse_mask),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb_rc_channel_axis_mapper_top: done, errors");
      $finish;
    end
  end

  // Updates the channel state for one accepted word and returns the channel's view.
  function automatic chan_word_t map_event(input logic [FUNC_W-1:0] fn, input logic is_axis,
                                           input logic [CH_W-1:0] ch,
                                           input logic signed [AXIS_W-1:0] axis);
    int a, d, t, prod, q, v;
    logic lo, hi;
    chan_word_t r;
    r = '0;
    r.channel = ch;
    if (int'(ch) >= RCAM_CHANNELS) begin
      r.mask = rev_mask;
      return r;
    end
    a = axis;
    d = int'(dz_shadow);
    if (fn == FUNC_MAP && is_axis && rev_mask[ch]) a = -a;
    lo = a < -d;
    hi = a > d;
    case (fn)
      FUNC_MAP: begin
        if (is_axis) begin
          t = lo ? a + d : (hi ? a - d : 0);
          prod = t * int'(gain_mem[ch]);
          q = prod / 100;
          if (prod < 0 && prod % 100 != 0) q = q - 1;  // floor, not truncate
          v = q + int'(offset_mem[ch]);
          if (v > PULSE_MAX) v = PULSE_MAX;
          if (v < PULSE_MIN) v = PULSE_MIN;
          pulse_mem[ch] = v[PULSE_W-1:0];
        end
      end
      FUNC_TRIM: begin
        if (lo && int'(offset_mem[ch]) > OFFSET_MIN) offset_mem[ch] = offset_mem[ch] - 1'b1;
        else if (hi && int'(offset_mem[ch]) < OFFSET_MAX) offset_mem[ch] = offset_mem[ch] + 1'b1;
      end
      FUNC_GAIN: begin
        if (lo && int'(gain_mem[ch]) >= GAIN_DEC_MIN) gain_mem[ch] = gain_mem[ch] - 1'b1;
        else if (hi && int'(gain_mem[ch]) <= GAIN_INC_MAX) gain_mem[ch] = gain_mem[ch] + 1'b1;
      end
      FUNC_REV: begin
        if (lo) rev_mask[ch] = 1'b1;
        else if (hi) rev_mask[ch] = 1'b0;
      end
    endcase
    r.pulse  = pulse_mem[ch];
    r.offset = offset_mem[ch];
    r.gain   = gain_mem[ch];
    r.mask   = rev_mask;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mism_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // driver: holds a word until it is taken, then predicts its result
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        chan_q.push_back(map_event(in_func, in_event_is_axis, in_channel, in_axis_value));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_word = word_q.pop_front();
          in_valid         <= 1'b1;
          in_func          <= next_word.func;
          in_event_is_axis <= next_word.is_axis;
          in_channel       <= next_word.channel;
          in_axis_value    <= next_word.axis;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken result word, runs the stall pattern and long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (chan_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word, channel %0d", out_channel));
        end else begin
          want_word = chan_q.pop_front();
          check_field("channel", out_channel, want_word.channel);
          check_field("pulse_value", out_pulse_value, want_word.pulse);
          check_field("trim_offset", out_trim_offset, want_word.offset);
          check_field("gain_hundredths", out_gain_hundredths, want_word.gain);
          check_field("reverse_mask", out_reverse_mask, want_word.mask);
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  task automatic add_word(input logic [FUNC_W-1:0] fn, input logic is_axis,
                          input logic [CH_W-1:0] ch, input int axis);
    axis_word_t w;
    w.func = fn;
    w.is_axis = is_axis;
    w.channel = ch;
    w.axis = axis[AXIS_W-1:0];
    word_q.push_back(w);
    queued_cnt++;
  endtask

  function automatic int rand_axis();
    int sel, v;
    sel = $urandom_range(9);
    if (sel < 4) v = int'($urandom_range(65534)) - 32767;
    else if (sel < 6) v = int'($urandom_range(300)) - 150;
    else if (sel < 7) v = $urandom_range(1) ? 32767 : -32767;
    else begin
      // on the deadzone edge or one step either side of it
      v = int'(dz_shadow) + int'($urandom_range(2)) - 1;
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  // Mostly runs of trim/gain steps on one channel so the limits get reached.
  task automatic gen_words(input int n);
    int left, len, kind, mag;
    logic dir;
    logic [FUNC_W-1:0] fn;
    logic [CH_W-1:0] ch;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(9);
      len = (kind < 4) ? $urandom_range(70, 1) : $urandom_range(8, 1);
      if (len > left) len = left;
      fn = $urandom_range(1) ? FUNC_TRIM : FUNC_GAIN;
      ch = CH_W'($urandom);
      dir = 1'($urandom);
      for (int k = 0; k < len; k++) begin
        if (kind < 4) begin
          mag = int'(dz_shadow) + 1 + int'($urandom_range(32766 - int'(dz_shadow)));
          add_word(fn, 1'($urandom), ch, dir ? mag : -mag);
        end else if (kind < 8) begin
          add_word(FUNC_MAP, $urandom_range(9) != 0, CH_W'($urandom), rand_axis());
        end else if (kind < 9) begin
          add_word(FUNC_REV, 1'($urandom), CH_W'($urandom), rand_axis());
        end else begin
          add_word(FUNC_W'($urandom), 1'($urandom), CH_W'($urandom),
                   int'($urandom_range(65534)) - 32767);
        end
      end
      left -= len;
    end
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == DZ_ADDR) dz_shadow = data[DZ_W-1:0];
  endtask

  // sender pauses here until every result word is back
  task automatic drain();
    while (accepted_cnt != queued_cnt || chan_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_phase(input int dz, input int src_pct, input int sink_pct,
                           input int n);
    write_reg(DZ_ADDR, dz);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    gen_words(n);
    drain();
  endtask

  initial begin
    for (int i = 0; i < RCAM_CHANNELS; i++) begin
      pulse_mem[i]  = PULSE_RESET;
      offset_mem[i] = (i == 0) ? OFFSET0_RESET : OFFSET_RESET;
      gain_mem[i]   = GAIN_RESET;
    end
    rev_mask  = REVERSE_RESET;
    dz_shadow = DZ_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed words at reset settings
    add_word(FUNC_MAP, 1'b1, 3'd0, 32767);     // clamps high
    add_word(FUNC_MAP, 1'b1, 3'd0, -32767);    // clamps low
    add_word(FUNC_MAP, 1'b1, 3'd1, 0);
    add_word(FUNC_MAP, 1'b1, 3'd1, 20);        // deadzone edge
    add_word(FUNC_MAP, 1'b1, 3'd1, 21);
    add_word(FUNC_MAP, 1'b1, 3'd1, -21);       // floor of a negative product
    add_word(FUNC_MAP, 1'b1, 3'd1, -20);
    add_word(FUNC_MAP, 1'b0, 3'd2, 30000);     // not an axis event
    add_word(FUNC_MAP, 1'b1, 3'd3, 10000);     // reversed channel
    add_word(FUNC_MAP, 1'b1, 3'd3, -32767);
    add_word(FUNC_TRIM, 1'b1, 3'd4, 100);
    add_word(FUNC_TRIM, 1'b0, 3'd4, -32767);
    add_word(FUNC_TRIM, 1'b1, 3'd4, 20);
    add_word(FUNC_TRIM, 1'b1, 3'd4, -21);
    add_word(FUNC_GAIN, 1'b1, 3'd5, 32767);
    add_word(FUNC_GAIN, 1'b0, 3'd5, -21);
    add_word(FUNC_GAIN, 1'b1, 3'd5, -20);
    add_word(FUNC_MAP, 1'b1, 3'd5, 5000);
    add_word(FUNC_REV, 1'b1, 3'd6, -21);
    add_word(FUNC_MAP, 1'b1, 3'd6, 12345);
    add_word(FUNC_REV, 1'b0, 3'd6, 21);
    add_word(FUNC_REV, 1'b1, 3'd6, 0);
    add_word(FUNC_REV, 1'b1, 3'd3, 32767);
    add_word(FUNC_MAP, 1'b1, 3'd3, 10000);
    add_word(FUNC_MAP, 1'b1, 3'd7, -1);
    drain();

    run_phase(0, 0, 0, 200);
    run_phase(127, 65, 0, 200);
    run_phase($urandom_range(127), 0, 65, 200);
    run_phase($urandom_range(127), 28, 28, 200);

    // long receiver hold-off while the sender keeps offering
    write_reg(DZ_ADDR, $urandom_range(60));
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_request = 400;
    gen_words(100);
    drain();

    write_reg(UNUSED_ADDR, 32'h0000_0055);
    run_phase(DZ_RESET, 0, 0, 200);

    if (mism_cnt == 0) begin
      $display("tb_rc_channel_axis_mapper_top: done, clean");
    end else begin
      $display("tb_rc_channel_axis_mapper_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rcam_pkg.sv
rtl/core/rcam_ram.sv
rtl/core/rcam_store.sv
rtl/core/rcam_cfg.sv
rtl/core/rc_channel_axis_mapper_top.sv
rtl/core/rcam_checker.sv
sim/tb_rc_channel_axis_mapper_top.sv
